### hdl/b2d_pkg.sv
// Shared constants and controller/datapath interface types for the
// binary to decimal ASCII converter. No dependencies.
`timescale 1ns / 1ps

package b2d_pkg;

   localparam int MAX_DIGITS = 10;
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 6;
   localparam int BCD_W      = 4 * MAX_DIGITS;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the input value, clear the digit register
      logic shift;  // one double-dabble step
      logic drop;   // discard the top digit (leading zero)
      logic emit;   // move the top digit into the output register
      logic last;   // flag the emitted digit as the final one
   } b2d_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic top_zero;  // top digit of the digit register is zero
      logic out_free;  // output register can take a digit this cycle
   } b2d_status_type;

endpackage

### hdl/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter: ties the controller
// to the datapath. Depends on b2d_pkg, b2d_ctrl and b2d_datapath.
`timescale 1ns / 1ps

// Sequence per value: accept the input beat, 32 double-dabble steps, up to
// MAX_DIGITS-1 leading-zero drops, then one emit per digit; the first digit is
// valid on rsp_ after the first emit. A new value is accepted only once the last
// digit is in the output register; an emit waits while that register holds an untaken digit.
// Reset (synchronous, active high) clears the controller state and the
// output valid; req_ready is registered and rises in the cycle after reset drops.
module binary_to_decimal_ascii_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [b2d_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [b2d_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_char
);
   import b2d_pkg::*;

   // command and status between the sequencer and the datapath
   b2d_cmd_type    cmd;
   b2d_status_type status;

   // sequencer: load, convert, drop leading zeros, emit one beat per digit
   b2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: the output register lets a new value load while the final
   // digit of the previous one still waits for rsp_ready
   b2d_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

### hdl/b2d_datapath.sv
// Datapath of the converter: binary shift register, BCD digit register with
// add-3 correction, and the output register. Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  b2d_pkg::b2d_cmd_type          cmd,
   output b2d_pkg::b2d_status_type       status,
   input  logic [b2d_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [b2d_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_char
);
   import b2d_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   bcd_adj;
   logic [3:0]         top_digit;
   logic               bcd_legal;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_digit_char_ff, rsp_digit_char_in;
   logic               rsp_last_char_ff, rsp_last_char_in;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   // add 3 to every digit of 5 or more ahead of the shift
   always_comb begin
      bcd_adj   = bcd_ff;
      bcd_legal = 1'b1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end
         if (bcd_ff[4*i +: 4] > 4'd9) begin
            bcd_legal = 1'b0;
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (cmd.load) begin
         bin_in = req_value;
         bcd_in = '0;
      end else if (cmd.shift) begin
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
      end else if (cmd.drop || cmd.emit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   assign status.top_zero = (top_digit == 4'd0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_digit_char_in = rsp_digit_char_ff;
      rsp_last_char_in  = rsp_last_char_ff;
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_digit_char_in = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
         rsp_last_char_in  = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff            <= bin_in;
      bcd_ff            <= bcd_in;
      rsp_digit_char_ff <= rsp_digit_char_in;
      rsp_last_char_ff  <= rsp_last_char_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last_char  = rsp_last_char_ff;

   a_emit_is_digit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> top_digit <= 4'd9)
      else $error("emitted digit out of decimal range");

   a_shift_keeps_bcd: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |=> bcd_legal)
      else $error("digit register left non-decimal after shift");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted digit not presented");

endmodule

### hdl/b2d_ctrl.sv
// Controller of the converter: sequences load, 32 conversion steps,
// leading-zero drop and digit emission. Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  b2d_pkg::b2d_status_type  status,
   output b2d_pkg::b2d_cmd_type     cmd
);
   import b2d_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   req_ready_ff, req_ready_in;

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               dig_cnt_in = DIG_CNT_W'(MAX_DIGITS - 1);
               state_in   = ST_SCAN;
            end else begin
               bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            end
         end
         ST_SCAN, ST_EMIT: begin
            if (state_ff == ST_SCAN && status.top_zero && dig_cnt_ff != '0) begin
               // drop a leading zero
               cmd.drop   = 1'b1;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = (dig_cnt_ff == '0);
               if (dig_cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
                  state_in   = ST_EMIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      req_ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("digit emitted over a pending output");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while a value is in conversion");

   a_drop_keeps_units: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |-> (dig_cnt_ff != '0) && !cmd.emit)
      else $error("units digit dropped");

endmodule

### verif/testbench.sv
// Self-checking testbench for binary_to_decimal_ascii_core: a directed table then random
// values, each beat checked against a row's own text or a digit-expansion predictor.
// Depends on b2d_pkg and the RTL of binary_to_decimal_ascii_core.
`timescale 1ns / 1ps

module testbench;
   import b2d_pkg::*;

   localparam int DEC_RADIX      = 10;
   localparam int TEXT_W         = 80;       // ten ASCII characters, right-aligned
   localparam int ROW_COUNT      = 19;
   localparam int RANDOM_PER_SET = 88;
   localparam int BURST_ITEMS    = 12;
   localparam int HOLD_OFF_LEN   = 200;
   localparam int MAX_GAP        = 45;
   localparam int DRAIN_CYCLES   = 80;       // load + 32 shifts + leading-zero drops, with margin
   localparam int CYCLE_LIMIT    = 800000;
   localparam int MAX_REPORTS    = 40;

   localparam int unsigned POW10 [10] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
      32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
   };

   // one expected response beat, tagged with the value that caused it
   typedef struct {
      logic [CHAR_W-1:0]  digit_char;
      logic               last_char;
      logic [VALUE_W-1:0] source_value;
   } digit_beat_type;

   // a row of the directed table; an all-zero text means "ask the predictor"
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [TEXT_W-1:0]  text;
   } digit_row_type;

   localparam digit_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd7,          "7"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd99,         '0},
      '{32'd100,        '0},
      '{32'd101,        '0},
      '{32'd100000,     "100000"},
      '{32'd999999999,  "999999999"},
      '{32'd1000000000, "1000000000"},
      '{32'd1000000001, '0},
      '{32'd1234567890, '0},
      '{32'h5555_5555,  '0},
      '{32'hAAAA_AAAA,  '0},
      '{32'h8000_0000,  '0},
      '{32'd4000000000, '0},
      '{32'd4294967294, '0},
      '{32'd4294967295, "4294967295"}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CHAR_W-1:0]   rsp_digit_char;
   logic                rsp_last_char;

   digit_beat_type pending_digits [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;   // chance per item that the sender goes quiet first
   int          stall_pct = 0;       // chance per cycle that the receiver drops ready
   int          hold_off_requests = 0;
   int          hold_off_seen = 0;
   int          hold_off_left = 0;

   binary_to_decimal_ascii_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_char  (rsp_last_char)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Predictor: split the value into MAX_DIGITS decimal positions, skip the
   // leading zeros, and queue one beat per digit left, most significant first.
   // A value of zero still yields a single '0'.
   function automatic void expand_decimal(input logic [VALUE_W-1:0] value);
      logic [3:0]         digs [MAX_DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 top;
      rest = value;
      top  = 0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digs[i] = 4'(rest % DEC_RADIX);
         rest    = rest / DEC_RADIX;
      end
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digs[i] != 4'd0) top = i;
      end
      for (int i = top; i >= 0; i--) begin
         pending_digits.push_back('{CHAR_W'(ASCII_ZERO + digs[i]), i == 0, value});
      end
   endfunction

   // Random value, spread over every digit count: full 32-bit noise, numbers below a power
   // of ten, values at or next to a power of ten, the top end, and small values up to 99.
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned k;
      logic [VALUE_W-1:0] v;
      k = $urandom_range(9, 1);
      case ($urandom_range(5))
         0, 1: v = $urandom();
         2: v = $urandom_range(POW10[k] - 1, 0);
         3: v = POW10[k] + $urandom_range(2) - 1;
         4: v = $urandom_range(32'hFFFF_FFFF, 32'd4000000000);
         default: v = $urandom_range(99);
      endcase
      return v;
   endfunction

   // Offer one value and hold it until the beat is taken. Drop valid for a
   // random gap first when the sender is in an idling phase. On acceptance,
   // queue the typed-in text if the row has one, else the predicted digits.
   task automatic offer_value(input logic [VALUE_W-1:0] value, input logic [TEXT_W-1:0] text);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(MAX_GAP, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (text == '0) begin
         expand_decimal(value);
      end else begin
         for (int b = TEXT_W / 8 - 1; b >= 0; b--) begin
            if (text[b*8 +: 8] != 8'd0)
               pending_digits.push_back('{text[b*8 +: CHAR_W], b == 0, value});
         end
      end
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) offer_value(pick_value(), '0);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever the stimulus
   // asks for one, counted down here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (hold_off_seen != hold_off_requests) begin
         hold_off_seen = hold_off_requests;
         hold_off_left = HOLD_OFF_LEN;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Checker: every accepted beat must match the oldest expected digit,
   // character and last flag checked separately.
   always @(posedge clock) begin
      digit_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_digits.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected beat: expected none, got char %0d last %0b",
                        $time, rsp_digit_char, rsp_last_char);
         end else begin
            want = pending_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: digit_char mismatch for %0d: expected %0d, got %0d",
                           $time, want.source_value, want.digit_char, rsp_digit_char);
            end
            if (rsp_last_char !== want.last_char) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: last_char mismatch for %0d: expected %0b, got %0b",
                           $time, want.source_value, want.last_char, rsp_last_char);
            end
         end
      end
   end

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d digits still expected", $time, pending_digits.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table: zero, single digits, powers of ten and their
      // neighbors, bit patterns, and the largest values, no idling.
      foreach (DIRECTED_ROWS[r]) offer_value(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].text);

      // Random values over the idling phases: none, sender idle, then receiver
      // stalling; both together come after the backpressure burst.
      run_random(RANDOM_PER_SET);
      send_idle_pct = 70;
      run_random(RANDOM_PER_SET);
      send_idle_pct = 0;
      stall_pct     = 70;
      run_random(RANDOM_PER_SET);

      // Backpressure: hold the receiver off for a long stretch while values
      // keep coming, so the block fills up and stalls its input.
      stall_pct = 0;
      hold_off_requests++;
      run_random(BURST_ITEMS);

      send_idle_pct = 27;
      stall_pct     = 27;
      run_random(RANDOM_PER_SET);

      // Drain: release the input, let every expected digit arrive, then
      // watch a little longer for stray beats.
      req_valid    <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### binary_to_decimal_ascii_core.f
hdl/b2d_pkg.sv
hdl/b2d_datapath.sv
hdl/b2d_ctrl.sv
hdl/binary_to_decimal_ascii_core.sv
verif/testbench.sv
